/* rtl/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Same-cycle implication, sampled on clk and masked during reset.
`define AST_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication.
`define AST_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

/* rtl/cbor_pkg.sv */
`default_nettype none
package cbor_pkg;
	localparam int STACK_DEPTH = 32;
	localparam int STACK_AW    = $clog2(STACK_DEPTH);
	localparam int NEST_LIMIT_DEF = 31;

	localparam logic [1:0] MODE_DATA    = 2'd0;
	localparam logic [1:0] MODE_VERDICT = 2'd1;
	localparam logic [1:0] MODE_RESTART = 2'd2;

	localparam logic [3:0] K_UINT    = 4'd0;
	localparam logic [3:0] K_NEGINT  = 4'd1;
	localparam logic [3:0] K_BYTES   = 4'd2;
	localparam logic [3:0] K_TEXT    = 4'd3;
	localparam logic [3:0] K_ARRAY   = 4'd4;
	localparam logic [3:0] K_MAP     = 4'd5;
	localparam logic [3:0] K_BOOL    = 4'd6;
	localparam logic [3:0] K_NULL    = 4'd7;
	localparam logic [3:0] K_PAYLOAD = 4'd11;
	localparam logic [3:0] K_VERDICT = 4'd12;

	localparam logic [2:0] V_OK      = 3'd0;
	localparam logic [2:0] V_BADHEAD = 3'd1;
	localparam logic [2:0] V_DEEP    = 3'd2;
	localparam logic [2:0] V_TRUNC   = 3'd3;
	localparam logic [2:0] V_SIMPLE  = 3'd4;

	typedef struct packed {
		logic                we;
		logic [STACK_AW-1:0] waddr;
		logic [63:0]         wdata;
		logic                re;
		logic [STACK_AW-1:0] raddr;
	} stk_req_t;
endpackage
`default_nettype wire

/* rtl/cbor_stream_token_parser_unit.sv */
`default_nettype none
// channel | dir | handshake            | payload
// in      | in  | in_valid / in_ready   | mode, data_byte
// out     | out | out_valid / out_ready | kind, value, nest_level, payload_last, verdict
//
// A request that only updates state leaves the unit ready for the next one; a
// completed head is decoded in S_FIN and loaded into the result register in
// S_EMIT, which waits for it to free up. Finishing an item visits S_CAS (stack
// read) then S_UPD (update) per enclosing level visited, and S_CAS again when
// the cascade reaches the root, as the level-count memory has registered reads.
// Reset clears all control state; the level-count memory needs no clearing.
// A waiting result does not block intake; the next token only waits for it.
module cbor_stream_token_parser_unit #(
	parameter int NEST_LIMIT = cbor_pkg::NEST_LIMIT_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  mode,
	input  wire logic [7:0]  data_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [3:0]       kind,
	output logic [63:0]      value,
	output logic [4:0]       nest_level,
	output logic             payload_last,
	output logic [2:0]       verdict
);
	import cbor_pkg::*;

	localparam logic [7:0] LIMIT = 8'(NEST_LIMIT);

	// sequencer states
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_FIN  = 3'd1;
	localparam logic [2:0] S_EMIT = 3'd2;
	localparam logic [2:0] S_CAS  = 3'd3;
	localparam logic [2:0] S_UPD  = 3'd4;

	// parse phases
	localparam logic [2:0] PH_HEAD    = 3'd0;
	localparam logic [2:0] PH_ARG     = 3'd1;
	localparam logic [2:0] PH_PAYLOAD = 3'd2;
	localparam logic [2:0] PH_DONE    = 3'd3;
	localparam logic [2:0] PH_ERROR   = 3'd4;

	logic [2:0]  st_q, phase_q, major_q, err_q;
	logic [4:0]  info_q;
	logic [3:0]  argleft_q;
	logic [63:0] arg_q, payleft_q;
	logic [5:0]  top_q;
	logic        donepend_q;
	logic [3:0]  tkind_q;
	logic [63:0] tval_q;
	logic [4:0]  tlvl_q;
	logic        tlast_q;
	logic [2:0]  tverd_q;
	logic        ovalid_q;

	stk_req_t    req;
	logic [63:0] rdata;
	logic [63:0] left;
	logic        out_free;
	logic [5:0]  top_m1;

	cbor_lvl_mem u_mem (
		.clk  (clk),
		.req  (req),
		.rdata(rdata)
	);

	assign in_ready  = (st_q == S_IDLE);
	assign out_free  = !ovalid_q || out_ready;
	assign left      = rdata - 64'd1;
	assign top_m1    = top_q - 6'd1;

	// Stack accesses: push in S_FIN, read in S_CAS, write-back in S_UPD.
	// The sequencer never overlaps them, so no forwarding is needed.
	always_comb begin
		req.we    = 1'b0;
		req.waddr = top_q[STACK_AW-1:0];
		req.wdata = 64'd1;
		req.re    = (st_q == S_CAS);
		req.raddr = top_m1[STACK_AW-1:0];
		if (st_q == S_FIN && phase_q != PH_ERROR) begin
			unique case (major_q)
				3'd4: begin
					req.we    = (arg_q != 64'd0);
					req.wdata = arg_q;
				end
				3'd5: begin
					req.we    = (arg_q != 64'd0);
					req.wdata = arg_q[63] ? '1 : {arg_q[62:0], 1'b0};
				end
				3'd6: req.we = 1'b1;
				default: req.we = 1'b0;
			endcase
		end else if (st_q == S_UPD && left != 64'd0) begin
			req.we    = 1'b1;
			req.waddr = top_m1[STACK_AW-1:0];
			req.wdata = left;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= S_IDLE;
			phase_q      <= PH_HEAD;
			major_q      <= '0;
			info_q       <= '0;
			argleft_q    <= '0;
			arg_q        <= '0;
			payleft_q    <= '0;
			top_q        <= '0;
			err_q        <= V_OK;
			donepend_q   <= 1'b0;
			tkind_q      <= '0;
			tval_q       <= '0;
			tlvl_q       <= '0;
			tlast_q      <= 1'b0;
			tverd_q      <= V_OK;
			ovalid_q     <= 1'b0;
			kind         <= '0;
			value        <= '0;
			nest_level   <= '0;
			payload_last <= 1'b0;
			verdict      <= V_OK;
		end else begin
			// load a new token when free, else drop the taken one
			if (st_q == S_EMIT && out_free) begin
				ovalid_q <= 1'b1;
			end else if (out_ready) begin
				ovalid_q <= 1'b0;
			end
			unique case (st_q)
				S_IDLE: begin
					if (in_valid) begin
						if (mode == MODE_RESTART) begin
							phase_q   <= PH_HEAD;
							major_q   <= '0;
							info_q    <= '0;
							argleft_q <= '0;
							arg_q     <= '0;
							payleft_q <= '0;
							top_q     <= '0;
							err_q     <= V_OK;
						end else if (mode == MODE_VERDICT) begin
							tkind_q    <= K_VERDICT;
							tval_q     <= '0;
							tlvl_q     <= '0;
							tlast_q    <= 1'b0;
							donepend_q <= 1'b0;
							tverd_q    <= (phase_q == PH_ERROR) ? err_q :
							              (phase_q == PH_DONE) ? V_OK : V_TRUNC;
							st_q       <= S_EMIT;
						end else if (mode == MODE_DATA) begin
							unique case (phase_q)
								PH_HEAD: begin
									if ({2'b00, top_q} > LIMIT || top_q > 6'd31) begin
										err_q   <= V_DEEP;
										phase_q <= PH_ERROR;
									end else if (data_byte[4:0] >= 5'd28) begin
										major_q <= data_byte[7:5];
										info_q  <= data_byte[4:0];
										err_q   <= V_BADHEAD;
										phase_q <= PH_ERROR;
									end else begin
										major_q <= data_byte[7:5];
										info_q  <= data_byte[4:0];
										if (data_byte[4:0] < 5'd24) begin
											arg_q     <= {59'd0, data_byte[4:0]};
											argleft_q <= '0;
											st_q      <= S_FIN;
										end else begin
											arg_q     <= '0;
											argleft_q <= 4'd1 << data_byte[1:0];
											phase_q   <= PH_ARG;
										end
									end
								end
								PH_ARG: begin
									arg_q     <= {arg_q[55:0], data_byte};
									argleft_q <= argleft_q - 4'd1;
									if (argleft_q == 4'd1) begin
										st_q <= S_FIN;
									end
								end
								PH_PAYLOAD: begin
									tkind_q    <= K_PAYLOAD;
									tval_q     <= {56'd0, data_byte};
									tlvl_q     <= top_q[4:0];
									tlast_q    <= (payleft_q == 64'd1);
									tverd_q    <= V_OK;
									payleft_q  <= payleft_q - 64'd1;
									donepend_q <= (payleft_q == 64'd1);
									st_q       <= S_EMIT;
								end
								default: ;
							endcase
						end
					end
				end
				S_FIN: begin
					// decode the completed head
					tlvl_q  <= top_q[4:0];
					tlast_q <= 1'b0;
					tverd_q <= V_OK;
					unique case (major_q)
						3'd0, 3'd1: begin
							tkind_q    <= {1'b0, major_q};
							tval_q     <= arg_q;
							donepend_q <= 1'b1;
							st_q       <= S_EMIT;
						end
						3'd2, 3'd3: begin
							tkind_q    <= {1'b0, major_q};
							tval_q     <= arg_q;
							donepend_q <= (arg_q == 64'd0);
							st_q       <= S_EMIT;
							if (arg_q != 64'd0) begin
								payleft_q <= arg_q;
								phase_q   <= PH_PAYLOAD;
							end
						end
						3'd4, 3'd5: begin
							tkind_q    <= {1'b0, major_q};
							tval_q     <= arg_q;
							donepend_q <= (arg_q == 64'd0);
							st_q       <= S_EMIT;
							if (arg_q != 64'd0) begin
								top_q   <= top_q + 6'd1;
								phase_q <= PH_HEAD;
							end
						end
						3'd6: begin
							// tag: drop the number, the child sits one level deeper
							top_q   <= top_q + 6'd1;
							phase_q <= PH_HEAD;
							st_q    <= S_IDLE;
						end
						default: begin
							if (info_q == 5'd20 || info_q == 5'd21) begin
								tkind_q    <= K_BOOL;
								tval_q     <= {63'd0, info_q[0]};
								donepend_q <= 1'b1;
								st_q       <= S_EMIT;
							end else if (info_q == 5'd22 || info_q == 5'd23) begin
								tkind_q    <= K_NULL;
								tval_q     <= '0;
								donepend_q <= 1'b1;
								st_q       <= S_EMIT;
							end else if (info_q >= 5'd25 && info_q <= 5'd27) begin
								tkind_q    <= 4'(info_q - 5'd17);
								tval_q     <= arg_q;
								donepend_q <= 1'b1;
								st_q       <= S_EMIT;
							end else begin
								err_q      <= V_SIMPLE;
								phase_q    <= PH_ERROR;
								donepend_q <= 1'b0;
								st_q       <= S_IDLE;
							end
						end
					endcase
				end
				S_EMIT: begin
					// hold the token until the result register frees up
					if (out_free) begin
						kind         <= tkind_q;
						value        <= tval_q;
						nest_level   <= tlvl_q;
						payload_last <= tlast_q;
						verdict      <= tverd_q;
						st_q         <= donepend_q ? S_CAS : S_IDLE;
					end
				end
				S_CAS: begin
					// item complete: read the enclosing level's count, or finish
					if (top_q == 6'd0) begin
						phase_q <= PH_DONE;
						st_q    <= S_IDLE;
					end else begin
						st_q <= S_UPD;
					end
				end
				S_UPD: begin
					if (left != 64'd0) begin
						phase_q <= PH_HEAD;
						st_q    <= S_IDLE;
					end else begin
						// level exhausted: pop and continue the cascade
						top_q <= top_m1;
						st_q  <= S_CAS;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = ovalid_q;
endmodule
`default_nettype wire

/* rtl/cbor_lvl_mem.sv */
`default_nettype none
module cbor_lvl_mem (
	input  wire logic              clk,
	input  wire cbor_pkg::stk_req_t req,
	output logic [63:0]            rdata
);
	import cbor_pkg::*;

	logic [63:0] mem [STACK_DEPTH];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata <= mem[req.raddr];
		end
	end
endmodule
`default_nettype wire

/* rtl/cbor_chk.sv */
`default_nettype none
`include "assert_macros.svh"
module cbor_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [3:0]  kind,
	input wire logic [63:0] value,
	input wire logic [4:0]  nest_level,
	input wire logic        payload_last,
	input wire logic [2:0]  verdict
);
	import cbor_pkg::*;

	`AST_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(kind) && $stable(value), "result changed while stalled")
	`AST_NOW(a_verdict_only, out_valid && kind != K_VERDICT, verdict == V_OK, "verdict on a data token")
	`AST_NOW(a_verdict_root, out_valid && kind == K_VERDICT, nest_level == 5'd0 && value == 64'd0, "verdict token not at root")
	`AST_NOW(a_last_payload, out_valid && payload_last, kind == K_PAYLOAD, "last mark off a payload byte")
endmodule

bind cbor_stream_token_parser_unit cbor_chk u_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.kind        (kind),
	.value       (value),
	.nest_level  (nest_level),
	.payload_last(payload_last),
	.verdict     (verdict)
);
`default_nettype wire
